### hw/rtl/cpe_pkg.sv
`default_nettype none

package cpe_pkg;

	localparam int SERIES_TERMS  = 9;
	localparam int CORDIC_STAGES = 24;

	localparam int SER_LAT  = SERIES_TERMS + 3;
	localparam int COR_LAT  = CORDIC_STAGES + 2;
	localparam int PIPE_LAT = SER_LAT + COR_LAT + 3;

	localparam int ACC_W = 36;
	localparam int XW    = 42;

	localparam logic signed [33:0] Q28_PI      = 34'sd843314857;
	localparam logic signed [33:0] Q28_HALF_PI = 34'sd421657428;
	localparam logic signed [33:0] Q28_TWO_PI  = 34'sd1686629713;
	localparam logic signed [31:0] INV_GAIN_Q30 = 32'sd652032874;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCALE_X     = 3'd0,
		REG_SCALE_Y     = 3'd1,
		REG_RECIP_X     = 3'd2,
		REG_RECIP_PROD  = 3'd3,
		REG_START_ARC   = 3'd4,
		REG_START_HEAD  = 3'd5,
		REG_START_STAT  = 3'd6
	} cfg_reg_t;

	function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
			input int unsigned n);
		return (v + (64'sd1 <<< (n - 1))) >>> n;
	endfunction

	function automatic logic fits32(input logic signed [63:0] v);
		return (v[63:31] == '0) || (v[63:31] == '1);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (fits32(v)) begin
			r = $signed(v[31:0]);
		end else if (v[63]) begin
			r = 32'sh8000_0000;
		end else begin
			r = 32'sh7fff_ffff;
		end
		return r;
	endfunction

	function automatic logic [31:0] series_coef(input int k);
		logic [31:0] c;
		case (k)
			1:       c = 32'd715827883;
			2:       c = 32'd107374182;
			3:       c = 32'd12782641;
			4:       c = 32'd1242757;
			5:       c = 32'd101680;
			6:       c = 32'd7170;
			7:       c = 32'd444;
			8:       c = 32'd24;
			9:       c = 32'd1;
			default: c = 32'd0;
		endcase
		return c;
	endfunction

	function automatic logic signed [31:0] series_term(input logic signed [31:0] pw,
			input int k);
		logic signed [63:0] pr;
		logic signed [63:0] r;
		pr = 64'(pw) * 64'($signed({1'b0, series_coef(k)}));
		r = rnd_shift(pr, 32);
		if (((k >> 1) & 1) == 1) begin
			r = -r;
		end
		return $signed(r[31:0]);
	endfunction

	function automatic logic [27:0] atan_q28(input int i);
		logic [27:0] a;
		case (i)
			0:       a = 28'd210828714;
			1:       a = 28'd124459457;
			2:       a = 28'd65760959;
			3:       a = 28'd33381290;
			4:       a = 28'd16755422;
			5:       a = 28'd8385879;
			6:       a = 28'd4193963;
			7:       a = 28'd2097109;
			8:       a = 28'd1048571;
			9:       a = 28'd524287;
			10:      a = 28'd262144;
			11:      a = 28'd131072;
			12:      a = 28'd65536;
			13:      a = 28'd32768;
			14:      a = 28'd16384;
			15:      a = 28'd8192;
			16:      a = 28'd4096;
			17:      a = 28'd2048;
			18:      a = 28'd1024;
			19:      a = 28'd512;
			20:      a = 28'd256;
			21:      a = 28'd128;
			22:      a = 28'd64;
			23:      a = 28'd32;
			24:      a = 28'd16;
			25:      a = 28'd8;
			26:      a = 28'd4;
			27:      a = 28'd2;
			28:      a = 28'd1;
			default: a = 28'd0;
		endcase
		return a;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/cpe_series.sv
`default_nettype none

module cpe_series (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] arc,
	input  logic signed [31:0] rcp_x,
	input  logic signed [31:0] scl_x,
	input  logic signed [31:0] scl_y,
	output logic signed [31:0] px,
	output logic signed [31:0] py,
	output logic               ok
);

	localparam int NT = cpe_pkg::SERIES_TERMS;
	localparam int AW = cpe_pkg::ACC_W;

	typedef struct packed {
		logic signed [31:0]   pw;
		logic signed [31:0]   t2;
		logic signed [AW-1:0] acx;
		logic signed [AW-1:0] acy;
		logic                 ok;
	} ser_stage_t;

	logic signed [31:0] t_s1;
	logic               ok_s1;
	ser_stage_t         st_sk [NT];
	logic signed [31:0] sx_sf, sy_sf;
	logic               ok_sf;
	logic signed [31:0] px_sp, py_sp;
	logic               ok_sp;

	logic signed [63:0] t_r, t2_r;

	always_comb begin
		t_r  = cpe_pkg::rnd_shift(64'(arc) * 64'(rcp_x), 16);
		t2_r = cpe_pkg::rnd_shift(64'(t_s1) * 64'(t_s1), 28);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1      <= cpe_pkg::sat32(t_r);
			ok_s1     <= cpe_pkg::fits32(t_r);
			st_sk[0]  <= '{pw: t_s1, t2: cpe_pkg::sat32(t2_r), acx: AW'(t_s1),
				acy: '0, ok: ok_s1 & cpe_pkg::fits32(t2_r)};
		end
	end

	for (genvar k = 1; k < NT; k++) begin : g_pow
		logic signed [63:0]   p_r;
		logic signed [31:0]   tm;
		logic signed [AW-1:0] ax_n, ay_n;

		always_comb begin
			p_r  = cpe_pkg::rnd_shift(64'(st_sk[k-1].pw) * 64'(st_sk[k-1].t2), 28);
			tm   = cpe_pkg::series_term(st_sk[k-1].pw, k - 1);
			ax_n = st_sk[k-1].acx;
			ay_n = st_sk[k-1].acy;
			if (k > 1) begin
				if (((k - 1) & 1) == 0) begin
					ax_n = st_sk[k-1].acx + AW'(tm);
				end else begin
					ay_n = st_sk[k-1].acy + AW'(tm);
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st_sk[k] <= '{pw: cpe_pkg::sat32(p_r), t2: st_sk[k-1].t2, acx: ax_n,
					acy: ay_n, ok: st_sk[k-1].ok & cpe_pkg::fits32(p_r)};
			end
		end
	end

	logic signed [31:0] tm_l;
	logic signed [63:0] sx_w, sy_w, px_r, py_r;

	always_comb begin
		tm_l = cpe_pkg::series_term(st_sk[NT-1].pw, NT - 1);
		sx_w = 64'(st_sk[NT-1].acx);
		sy_w = 64'(st_sk[NT-1].acy);
		if (((NT - 1) & 1) == 0) begin
			sx_w = 64'(st_sk[NT-1].acx) + 64'(tm_l);
		end else begin
			sy_w = 64'(st_sk[NT-1].acy) + 64'(tm_l);
		end
		px_r = cpe_pkg::rnd_shift(64'(scl_x) * 64'(sx_sf), 28);
		py_r = cpe_pkg::rnd_shift(64'(scl_y) * 64'(sy_sf), 28);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_sf <= cpe_pkg::sat32(sx_w);
			sy_sf <= cpe_pkg::sat32(sy_w);
			ok_sf <= st_sk[NT-1].ok & cpe_pkg::fits32(sx_w) & cpe_pkg::fits32(sy_w);
			px_sp <= cpe_pkg::sat32(px_r);
			py_sp <= cpe_pkg::sat32(py_r);
			ok_sp <= ok_sf & cpe_pkg::fits32(px_r) & cpe_pkg::fits32(py_r);
		end
	end

	assign px = px_sp;
	assign py = py_sp;
	assign ok = ok_sp;

endmodule

`default_nettype wire

### hw/rtl/cpe_cordic.sv
`default_nettype none

module cpe_cordic (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] vx,
	input  logic signed [31:0] vy,
	input  logic signed [32:0] ang,
	output logic signed [31:0] ox,
	output logic signed [31:0] oy,
	output logic               ok
);

	localparam int M  = cpe_pkg::CORDIC_STAGES;
	localparam int XW = cpe_pkg::XW;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [31:0]   a;
	} cor_stage_t;

	logic signed [XW-1:0] x_s1, y_s1;
	logic signed [31:0]   a_s1;
	logic                 neg_s1;
	cor_stage_t           cs_sk [M];
	logic signed [31:0]   ox_sr, oy_sr;
	logic                 ok_sr;

	logic signed [63:0] mx, my;
	logic signed [33:0] ar;
	logic               neg;

	always_comb begin
		mx  = (64'(vx) * 64'(cpe_pkg::INV_GAIN_Q30)) >>> 22;
		my  = (64'(vy) * 64'(cpe_pkg::INV_GAIN_Q30)) >>> 22;
		ar  = 34'(ang);
		neg = 1'b0;
		if (ar > cpe_pkg::Q28_PI) ar = ar - cpe_pkg::Q28_TWO_PI;
		if (ar > cpe_pkg::Q28_PI) ar = ar - cpe_pkg::Q28_TWO_PI;
		if (ar < -cpe_pkg::Q28_PI) ar = ar + cpe_pkg::Q28_TWO_PI;
		if (ar < -cpe_pkg::Q28_PI) ar = ar + cpe_pkg::Q28_TWO_PI;
		if (ar > cpe_pkg::Q28_HALF_PI) begin
			neg = 1'b1;
			ar  = ar - cpe_pkg::Q28_PI;
		end else if (ar < -cpe_pkg::Q28_HALF_PI) begin
			neg = 1'b1;
			ar  = ar + cpe_pkg::Q28_PI;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= $signed(mx[XW-1:0]);
			y_s1   <= $signed(my[XW-1:0]);
			a_s1   <= $signed(ar[31:0]);
			neg_s1 <= neg;
		end
	end

	for (genvar i = 0; i < M; i++) begin : g_iter
		logic signed [XW-1:0] xi, yi, xs, ys;
		logic signed [31:0]   ai, at;
		cor_stage_t           nx;

		if (i == 0) begin : g_first
			assign xi = neg_s1 ? -x_s1 : x_s1;
			assign yi = neg_s1 ? -y_s1 : y_s1;
			assign ai = a_s1;
		end else begin : g_next
			assign xi = cs_sk[i-1].x;
			assign yi = cs_sk[i-1].y;
			assign ai = cs_sk[i-1].a;
		end

		always_comb begin
			xs = xi >>> i;
			ys = yi >>> i;
			at = $signed({4'b0, cpe_pkg::atan_q28(i)});
			if (ai >= 0) begin
				nx = '{x: xi - ys, y: yi + xs, a: ai - at};
			end else begin
				nx = '{x: xi + ys, y: yi - xs, a: ai + at};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cs_sk[i] <= nx;
			end
		end
	end

	logic signed [63:0] xw, yw, xr, yr;

	always_comb begin
		xw = 64'(cs_sk[M-1].x);
		yw = 64'(cs_sk[M-1].y);
		xr = cpe_pkg::rnd_shift(xw, 8);
		yr = cpe_pkg::rnd_shift(yw, 8);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ox_sr <= cpe_pkg::sat32(xr);
			oy_sr <= cpe_pkg::sat32(yr);
			ok_sr <= cpe_pkg::fits32(xr) & cpe_pkg::fits32(yr);
		end
	end

	assign ox = ox_sr;
	assign oy = oy_sr;
	assign ok = ok_sr;

endmodule

`default_nettype wire

### hw/rtl/clothoid_point_evaluator.sv
`default_nettype none

// Clothoid point evaluator: one station/lateral pair in, one point out, one item per
// clock while out_ready does not stall it. Pipeline depth is set by the chain of power
// multiplies in the series unit followed by the CORDIC stages; out_ready low while a
// result waits freezes the whole pipeline. Configuration registers must be written
// through cfg_wr_en/cfg_index/cfg_wdata while no transfer is in flight; the block
// itself does not enforce this.
module clothoid_point_evaluator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [cpe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                     cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [31:0]              station,
	input  logic signed [31:0]              lateral,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [31:0]              pos_x,
	output logic signed [31:0]              pos_y,
	output logic signed [31:0]              heading_rad,
	output logic signed [31:0]              curvature,
	output logic                            valid_res
);

	localparam int LAT = cpe_pkg::PIPE_LAT;
	localparam int DLY = cpe_pkg::SER_LAT - 1;
	localparam int CL  = cpe_pkg::COR_LAT;

	typedef struct packed {
		logic signed [31:0] l;
		logic signed [31:0] lat;
		logic               ok;
	} fwd_t;

	typedef struct packed {
		logic signed [31:0] head;
		logic signed [31:0] curv;
		logic               ok;
	} tail_t;

	logic signed [31:0] scale_x_q, scale_y_q, rcp_x_q, rcp_p_q;
	logic signed [31:0] arc0_q, head0_q, stat0_q;
	logic [LAT-1:0]     pipe_v_q;
	logic               pipe_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_x_q <= '0;
			scale_y_q <= '0;
			rcp_x_q   <= '0;
			rcp_p_q   <= '0;
			arc0_q    <= '0;
			head0_q   <= '0;
			stat0_q   <= '0;
		end else if (cfg_wr_en) begin
			case (cpe_pkg::cfg_reg_t'(cfg_index))
				cpe_pkg::REG_SCALE_X:    scale_x_q <= $signed(cfg_wdata);
				cpe_pkg::REG_SCALE_Y:    scale_y_q <= $signed(cfg_wdata);
				cpe_pkg::REG_RECIP_X:    rcp_x_q   <= $signed(cfg_wdata);
				cpe_pkg::REG_RECIP_PROD: rcp_p_q   <= $signed(cfg_wdata);
				cpe_pkg::REG_START_ARC:  arc0_q    <= $signed(cfg_wdata);
				cpe_pkg::REG_START_HEAD: head0_q   <= $signed(cfg_wdata);
				cpe_pkg::REG_START_STAT: stat0_q   <= $signed(cfg_wdata);
				default: ;
			endcase
		end
	end

	assign out_valid = pipe_v_q[LAT-1];
	assign pipe_en   = !out_valid || out_ready;
	assign in_ready  = pipe_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_v_q <= '0;
		end else if (pipe_en) begin
			pipe_v_q <= {pipe_v_q[LAT-2:0], in_valid};
		end
	end

	// Arc parameter
	fwd_t               s1;
	fwd_t               dly_sd [DLY];
	logic signed [63:0] l_w;

	always_comb begin
		l_w = 64'(arc0_q) + 64'(station) - 64'(stat0_q);
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			s1        <= '{l: cpe_pkg::sat32(l_w), lat: lateral, ok: cpe_pkg::fits32(l_w)};
			dly_sd[0] <= s1;
			for (int j = 1; j < DLY; j++) begin
				dly_sd[j] <= dly_sd[j-1];
			end
		end
	end

	logic signed [31:0] x1, y1, x0, y0;
	logic               ok1, ok0;

	cpe_series u_ser_pt (
		.clk   (clk),
		.en    (pipe_en),
		.arc   (s1.l),
		.rcp_x (rcp_x_q),
		.scl_x (scale_x_q),
		.scl_y (scale_y_q),
		.px    (x1),
		.py    (y1),
		.ok    (ok1)
	);

	cpe_series u_ser_org (
		.clk   (clk),
		.en    (pipe_en),
		.arc   (arc0_q),
		.rcp_x (rcp_x_q),
		.scl_x (scale_x_q),
		.scl_y (scale_y_q),
		.px    (x0),
		.py    (y0),
		.ok    (ok0)
	);

	// Curvature, then heading and chord
	logic signed [31:0] l_s2, lat_s2, curv_s2;
	logic               ok_s2;
	logic signed [63:0] curv_r;

	always_comb begin
		curv_r = cpe_pkg::rnd_shift(64'(dly_sd[DLY-1].l) * 64'(rcp_p_q), 16);
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			l_s2    <= dly_sd[DLY-1].l;
			lat_s2  <= dly_sd[DLY-1].lat;
			curv_s2 <= cpe_pkg::sat32(curv_r);
			ok_s2   <= dly_sd[DLY-1].ok & cpe_pkg::fits32(curv_r);
		end
	end

	logic signed [31:0] dx_s3, dy_s3, head_s3, curv_s3, lat_s3;
	logic               ok_s3;
	logic signed [63:0] dx_w, dy_w, hd_w;

	always_comb begin
		dx_w = 64'(x1) - 64'(x0);
		dy_w = 64'(y1) - 64'(y0);
		hd_w = cpe_pkg::rnd_shift(64'(l_s2) * 64'(curv_s2), 17) - 64'(head0_q);
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			dx_s3   <= cpe_pkg::sat32(dx_w);
			dy_s3   <= cpe_pkg::sat32(dy_w);
			head_s3 <= cpe_pkg::sat32(hd_w);
			curv_s3 <= curv_s2;
			lat_s3  <= lat_s2;
			ok_s3   <= ok_s2 & ok1 & ok0 & cpe_pkg::fits32(dx_w) & cpe_pkg::fits32(dy_w)
				& cpe_pkg::fits32(hd_w);
		end
	end

	logic signed [32:0] rot_ang, nrm_ang;
	logic signed [31:0] rx, ry, nx, ny;
	logic               okr, okn;

	assign rot_ang = -{head0_q[31], head0_q};
	assign nrm_ang = {head_s3[31], head_s3};

	cpe_cordic u_cor_rot (
		.clk (clk),
		.en  (pipe_en),
		.vx  (dx_s3),
		.vy  (dy_s3),
		.ang (rot_ang),
		.ox  (rx),
		.oy  (ry),
		.ok  (okr)
	);

	cpe_cordic u_cor_nrm (
		.clk (clk),
		.en  (pipe_en),
		.vx  ('0),
		.vy  (lat_s3),
		.ang (nrm_ang),
		.ox  (nx),
		.oy  (ny),
		.ok  (okn)
	);

	tail_t tl_st [CL];

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			tl_st[0] <= '{head: head_s3, curv: curv_s3, ok: ok_s3};
			for (int j = 1; j < CL; j++) begin
				tl_st[j] <= tl_st[j-1];
			end
		end
	end

	// Output register
	logic signed [31:0] px_s4, py_s4, hd_s4, cv_s4;
	logic               ok_s4, deg_s4;
	logic signed [63:0] sx_w, sy_w;
	logic               deg;

	always_comb begin
		sx_w = 64'(rx) + 64'(nx);
		sy_w = 64'(ry) + 64'(ny);
		deg  = (scale_x_q == '0);
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			deg_s4 <= deg;
			if (deg) begin
				px_s4 <= '0;
				py_s4 <= '0;
				hd_s4 <= '0;
				cv_s4 <= '0;
				ok_s4 <= 1'b0;
			end else begin
				px_s4 <= cpe_pkg::sat32(sx_w);
				py_s4 <= cpe_pkg::sat32(sy_w);
				hd_s4 <= tl_st[CL-1].head;
				cv_s4 <= tl_st[CL-1].curv;
				ok_s4 <= tl_st[CL-1].ok & okr & okn & cpe_pkg::fits32(sx_w)
					& cpe_pkg::fits32(sy_w);
			end
		end
	end

	assign pos_x       = px_s4;
	assign pos_y       = py_s4;
	assign heading_rad = hd_s4;
	assign curvature   = cv_s4;
	assign valid_res   = ok_s4;

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!pipe_en |=> $stable(pipe_v_q))
		else $error("pipeline valid bits moved during stall");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> pipe_v_q[0])
		else $error("accepted transfer missing from first stage");

	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && deg_s4 |-> !valid_res && pos_x == '0 && pos_y == '0)
		else $error("degenerate element gave nonzero result");

endmodule

`default_nettype wire
